@@ src/csvrp_pkg.sv @@
package csvrp_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_CHAR    = 2'd0,
        REQ_EOF     = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_UNUSED  = 2'd3
    } req_t;

    // Action codes reported with each result
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_ERROR  = 2'd3
    } action_t;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_out;
        logic       end_of_record;
        logic       halted;
    } out_item_t;

endpackage

@@ src/csv_record_parser_fsm_core.sv @@
// Each result is registered in the result register, or in the skid register while
// the result register waits for m_ready. Throughput: one byte per cycle while s_ready
// is high; the one-hot state register updates in the same cycle as each input transfer.
// A two-entry output stage (result register plus skid register) takes one more
// input transfer while a result waits for m_ready; s_ready drops only when both hold one.
// Reset (aresetn low, synchronous): parser in record begin, no result pending.
module csv_record_parser_fsm_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  csvrp_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output csvrp_pkg::out_item_t  m_data
);
    import csvrp_pkg::*;

    typedef enum logic [7:0] {
        ST_REC_BEGIN   = 8'b0000_0001,
        ST_FIELD_BEGIN = 8'b0000_0010,
        ST_UNQUOTED    = 8'b0000_0100,
        ST_QUOTED      = 8'b0000_1000,
        ST_QUOTE_SEEN  = 8'b0001_0000,
        ST_CR_SEEN     = 8'b0010_0000,
        ST_REC_END     = 8'b0100_0000,
        ST_HALTED      = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        CL_COMMA = 3'd0,
        CL_QUOTE = 3'd1,
        CL_CR    = 3'd2,
        CL_LF    = 3'd3,
        CL_EOF   = 3'd4,
        CL_TEXT  = 3'd5
    } class_t;

    state_t    state_reg, state_next;
    class_t    item_class;
    action_t   act;
    out_item_t result;
    out_item_t out_reg, out_next;
    out_item_t skid_reg, skid_next;
    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    logic      in_xfer;

    assign s_ready = !skid_valid_reg;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Classify the incoming item
    always_comb begin
        if (s_data.req_type == REQ_EOF) begin
            item_class = CL_EOF;
        end else begin
            case (s_data.char_in)
                CHAR_COMMA: item_class = CL_COMMA;
                CHAR_QUOTE: item_class = CL_QUOTE;
                CHAR_CR:    item_class = CL_CR;
                CHAR_LF:    item_class = CL_LF;
                default:    item_class = CL_TEXT;
            endcase
        end
    end

    // Transition table: next state and action
    always_comb begin
        state_next = state_reg;
        act        = ACT_NONE;
        if (s_data.req_type == REQ_RESTART) begin
            state_next = ST_REC_BEGIN;
        end else if (s_data.req_type == REQ_CHAR || s_data.req_type == REQ_EOF) begin
            unique case (state_reg) inside
                ST_REC_BEGIN, ST_FIELD_BEGIN, ST_UNQUOTED: begin
                    case (item_class)
                        CL_COMMA: begin state_next = ST_FIELD_BEGIN; act = ACT_FLUSH; end
                        CL_QUOTE: begin
                            if (state_reg == ST_UNQUOTED) begin
                                act = ACT_APPEND;
                            end else begin
                                state_next = ST_QUOTED;
                            end
                        end
                        CL_CR:    begin state_next = ST_CR_SEEN; act = ACT_FLUSH; end
                        CL_LF:    begin state_next = ST_REC_END; act = ACT_FLUSH; end
                        CL_EOF: begin
                            // empty input ends the record without a flush
                            state_next = ST_REC_END;
                            act = (state_reg == ST_REC_BEGIN) ? ACT_NONE : ACT_FLUSH;
                        end
                        default:  begin state_next = ST_UNQUOTED; act = ACT_APPEND; end
                    endcase
                end
                ST_QUOTED: begin
                    case (item_class)
                        CL_QUOTE: state_next = ST_QUOTE_SEEN;
                        CL_EOF:   begin state_next = ST_HALTED; act = ACT_ERROR; end
                        default:  act = ACT_APPEND;
                    endcase
                end
                ST_QUOTE_SEEN: begin
                    case (item_class) inside
                        CL_COMMA: begin state_next = ST_FIELD_BEGIN; act = ACT_FLUSH; end
                        CL_QUOTE: begin state_next = ST_QUOTED; act = ACT_APPEND; end
                        CL_CR:    begin state_next = ST_CR_SEEN; act = ACT_FLUSH; end
                        CL_LF, CL_EOF: begin state_next = ST_REC_END; act = ACT_FLUSH; end
                        default:  begin state_next = ST_HALTED; act = ACT_ERROR; end
                    endcase
                end
                ST_CR_SEEN: begin
                    case (item_class) inside
                        CL_CR:         act = ACT_NONE;
                        CL_LF, CL_EOF: state_next = ST_REC_END;
                        default:       begin state_next = ST_HALTED; act = ACT_ERROR; end
                    endcase
                end
                ST_REC_END: act = ACT_NONE;
                // halted repeats the error until a restart
                ST_HALTED:  act = ACT_ERROR;
                default:    state_next = ST_REC_BEGIN;
            endcase
        end
    end

    // Result item for the current input
    always_comb begin
        result.action        = act;
        result.char_out      = (s_data.req_type == REQ_CHAR) ? s_data.char_in : 8'd0;
        result.end_of_record = (state_next == ST_REC_END);
        result.halted        = (state_next == ST_HALTED);
    end

    // Output register and skid register
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = in_xfer;
            end
        end else if (in_xfer) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_REC_BEGIN;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg <= state_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // Checks
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("parser state is not one-hot");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.end_of_record && m_data.halted))
        else $error("end of record and halted both set");

    a_halted_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.halted) |->
            (m_data.action == ACT_ERROR || m_data.action == ACT_NONE))
        else $error("halted result with append or flush action");

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

endmodule

@@ tb/sv/csv_parse_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the CSV parser, predicts one result per input
// transfer and compares every result transfer with the oldest prediction.
module csv_parse_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  csvrp_pkg::in_item_t   s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  csvrp_pkg::out_item_t  m_data,
    output int                    fail_cnt,
    output int                    pending_cnt
);
    import csvrp_pkg::*;

    // Parser states of the predictor
    typedef enum logic [2:0] {
        PS_REC_BEGIN   = 3'd0,
        PS_FIELD_BEGIN = 3'd1,
        PS_UNQUOTED    = 3'd2,
        PS_QUOTED      = 3'd3,
        PS_QUOTE_SEEN  = 3'd4,
        PS_CR_SEEN     = 3'd5,
        PS_REC_END     = 3'd6,
        PS_HALTED      = 3'd7
    } parse_state_t;

    // Byte classes seen by the transition logic
    typedef enum logic [2:0] {
        CL_COMMA,
        CL_QUOTE,
        CL_CR,
        CL_LF,
        CL_EOF,
        CL_TEXT
    } char_class_t;

    parse_state_t parser_st = PS_REC_BEGIN;
    action_t      stored_act = ACT_NONE;
    out_item_t    parse_results_q[$];
    out_item_t    want;
    int           n_err = 0;

    // Advance the predicted parser by one item and return its result
    function automatic out_item_t predict_parse(input in_item_t it);
        out_item_t    res;
        char_class_t  cls;
        parse_state_t nxt;
        action_t      act;
        res = '0;
        case (it.req_type)
            REQ_RESTART: begin
                parser_st  = PS_REC_BEGIN;
                stored_act = ACT_NONE;
            end
            REQ_CHAR, REQ_EOF: begin
                if (it.req_type == REQ_CHAR) begin
                    res.char_out = it.char_in;
                end
                if (it.req_type == REQ_EOF)          cls = CL_EOF;
                else if (it.char_in == CHAR_COMMA)   cls = CL_COMMA;
                else if (it.char_in == CHAR_QUOTE)   cls = CL_QUOTE;
                else if (it.char_in == CHAR_CR)      cls = CL_CR;
                else if (it.char_in == CHAR_LF)      cls = CL_LF;
                else                                 cls = CL_TEXT;
                nxt = parser_st;
                act = stored_act;
                case (parser_st)
                    PS_REC_BEGIN, PS_FIELD_BEGIN, PS_UNQUOTED: begin
                        case (cls)
                            CL_COMMA: begin nxt = PS_FIELD_BEGIN; act = ACT_FLUSH; end
                            CL_QUOTE: begin
                                // a quote inside an unquoted field is plain text
                                if (parser_st == PS_UNQUOTED) begin
                                    nxt = PS_UNQUOTED;
                                    act = ACT_APPEND;
                                end else begin
                                    nxt = PS_QUOTED;
                                    act = ACT_NONE;
                                end
                            end
                            CL_CR:    begin nxt = PS_CR_SEEN; act = ACT_FLUSH; end
                            CL_LF:    begin nxt = PS_REC_END; act = ACT_FLUSH; end
                            CL_EOF: begin
                                // empty input flushes nothing
                                nxt = PS_REC_END;
                                act = (parser_st == PS_REC_BEGIN) ? ACT_NONE : ACT_FLUSH;
                            end
                            default:  begin nxt = PS_UNQUOTED; act = ACT_APPEND; end
                        endcase
                    end
                    PS_QUOTED: begin
                        case (cls)
                            CL_QUOTE: begin nxt = PS_QUOTE_SEEN; act = ACT_NONE; end
                            CL_EOF:   begin nxt = PS_HALTED; act = ACT_ERROR; end
                            default:  begin nxt = PS_QUOTED; act = ACT_APPEND; end
                        endcase
                    end
                    PS_QUOTE_SEEN: begin
                        case (cls)
                            CL_COMMA:      begin nxt = PS_FIELD_BEGIN; act = ACT_FLUSH; end
                            CL_QUOTE:      begin nxt = PS_QUOTED; act = ACT_APPEND; end
                            CL_CR:         begin nxt = PS_CR_SEEN; act = ACT_FLUSH; end
                            CL_LF, CL_EOF: begin nxt = PS_REC_END; act = ACT_FLUSH; end
                            default:       begin nxt = PS_HALTED; act = ACT_ERROR; end
                        endcase
                    end
                    PS_CR_SEEN: begin
                        case (cls)
                            CL_CR:         begin nxt = PS_CR_SEEN; act = ACT_NONE; end
                            CL_LF, CL_EOF: begin nxt = PS_REC_END; act = ACT_NONE; end
                            default:       begin nxt = PS_HALTED; act = ACT_ERROR; end
                        endcase
                    end
                    // record end absorbs everything
                    PS_REC_END: act = ACT_NONE;
                    // halted keeps state and repeats the error
                    default: ;
                endcase
                parser_st  = nxt;
                stored_act = act;
                res.action = stored_act;
            end
            // unused request code: no state change, action none
            default: ;
        endcase
        res.end_of_record = (parser_st == PS_REC_END);
        res.halted        = (parser_st == PS_HALTED);
        return res;
    endfunction

    // Result transfers are checked before the prediction of this edge is queued:
    // a result never leaves in the cycle of its own input transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_results_q.delete();
            parser_st  = PS_REC_BEGIN;
            stored_act = ACT_NONE;
        end else begin
            if (m_valid && m_ready) begin
                if (parse_results_q.size() == 0) begin
                    $display("%0t: result transfer with none expected: actual %h",
                             $time, m_data);
                    n_err++;
                end else begin
                    want = parse_results_q.pop_front();
                    if (m_data.action !== want.action) begin
                        $display("%0t: action mismatch: expected %0d, actual %0d",
                                 $time, want.action, m_data.action);
                        n_err++;
                    end
                    if (m_data.char_out !== want.char_out) begin
                        $display("%0t: char_out mismatch: expected %h, actual %h",
                                 $time, want.char_out, m_data.char_out);
                        n_err++;
                    end
                    if (m_data.end_of_record !== want.end_of_record) begin
                        $display("%0t: end_of_record mismatch: expected %b, actual %b",
                                 $time, want.end_of_record, m_data.end_of_record);
                        n_err++;
                    end
                    if (m_data.halted !== want.halted) begin
                        $display("%0t: halted mismatch: expected %b, actual %b",
                                 $time, want.halted, m_data.halted);
                        n_err++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_results_q.push_back(predict_parse(s_data));
            end
        end
        fail_cnt    <= n_err;
        pending_cnt <= parse_results_q.size();
    end

endmodule

@@ tb/sv/tb_csv_record_parser_fsm_core.sv @@
`timescale 1ns / 1ps

module tb_csv_record_parser_fsm_core;
    import csvrp_pkg::*;

    localparam int ITEM_GOAL   = 950;
    localparam int CYCLE_LIMIT = 200000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_cnt;
    int pending_cnt;
    int n_items = 0;
    int cycles  = 0;
    bit quiet   = 1'b0;

    csv_record_parser_fsm_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    csv_parse_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls with a probability of 8 percent per draw, never during the quiet stretch
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 8);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // One input transfer, with an occasional gap in front of it
    task automatic push_item(input logic [1:0] req, input logic [7:0] ch, input bit counts);
        if (!quiet && $urandom_range(0, 99) < 3) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{req_type: req, char_in: ch};
        do @(posedge aclk); while (!s_ready);
        if (counts) n_items++;
    endtask

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0:       return CHAR_COMMA;
            1:       return CHAR_QUOTE;
            2:       return CHAR_CR;
            3:       return CHAR_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random byte that is none of the delimiters
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b inside {CHAR_COMMA, CHAR_QUOTE, CHAR_CR, CHAR_LF}) b = b ^ 8'h40;
        return b;
    endfunction

    // Restart, a few fields (quoted or not), a terminator, maybe some trailing bytes
    task automatic send_record();
        int         nf;
        int         len;
        logic [7:0] b;
        logic [1:0] r;
        push_item(REQ_RESTART, 8'($urandom_range(0, 255)), 1'b1);
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) push_item(REQ_CHAR, CHAR_COMMA, 1'b1);
            len = $urandom_range(0, 6);
            if ($urandom_range(0, 2) == 0) begin
                push_item(REQ_CHAR, CHAR_QUOTE, 1'b1);
                for (int i = 0; i < len; i++) begin
                    b = any_byte();
                    push_item(REQ_CHAR, b, 1'b1);
                    // embedded quote is doubled
                    if (b == CHAR_QUOTE) push_item(REQ_CHAR, CHAR_QUOTE, 1'b1);
                end
                push_item(REQ_CHAR, CHAR_QUOTE, 1'b1);
            end else begin
                for (int i = 0; i < len; i++) push_item(REQ_CHAR, plain_byte(), 1'b1);
            end
            // broken record: a stray byte or an early end of input
            if ($urandom_range(0, 29) == 0) begin
                r = 2'($urandom_range(0, 1));
                push_item(r, any_byte(), 1'b1);
            end
        end
        case ($urandom_range(0, 4))
            0: begin
                push_item(REQ_CHAR, CHAR_CR, 1'b1);
                push_item(REQ_CHAR, CHAR_LF, 1'b1);
            end
            1: push_item(REQ_CHAR, CHAR_LF, 1'b1);
            2: push_item(REQ_EOF, 8'($urandom_range(0, 255)), 1'b1);
            3: begin
                push_item(REQ_CHAR, CHAR_CR, 1'b1);
                push_item(REQ_CHAR, CHAR_CR, 1'b1);
                push_item(REQ_CHAR, CHAR_LF, 1'b1);
            end
            default: begin
                push_item(REQ_CHAR, CHAR_CR, 1'b1);
                push_item(REQ_EOF, 8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        // bytes after the record end are absorbed
        repeat ($urandom_range(0, 2)) begin
            r = 2'($urandom_range(0, 1));
            push_item(r, any_byte(), 1'b0);
        end
    endtask

    initial begin
        logic [1:0] r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty input, absorption in record end, unused code
        push_item(REQ_EOF,     8'h00,      1'b1);
        push_item(REQ_CHAR,    8'h78,      1'b1);
        push_item(REQ_EOF,     8'hFF,      1'b1);
        push_item(REQ_UNUSED,  8'hFF,      1'b0);
        push_item(REQ_RESTART, 8'hFF,      1'b1);
        // 00,"FF""" CR CR LF: doubled quote and repeated CR
        push_item(REQ_CHAR,    8'h00,      1'b1);
        push_item(REQ_CHAR,    CHAR_COMMA, 1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    8'hFF,      1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    CHAR_CR,    1'b1);
        push_item(REQ_CHAR,    CHAR_CR,    1'b1);
        push_item(REQ_CHAR,    CHAR_LF,    1'b1);
        // end of input inside quotes, then halted behavior
        push_item(REQ_RESTART, 8'h00,      1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_EOF,     8'h00,      1'b1);
        push_item(REQ_CHAR,    8'h61,      1'b1);
        push_item(REQ_UNUSED,  8'h00,      1'b0);
        // text after closing quote, then CR followed by a comma
        push_item(REQ_RESTART, 8'h00,      1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    CHAR_QUOTE, 1'b1);
        push_item(REQ_CHAR,    8'h7A,      1'b1);
        push_item(REQ_RESTART, 8'h00,      1'b1);
        push_item(REQ_CHAR,    CHAR_CR,    1'b1);
        push_item(REQ_CHAR,    CHAR_COMMA, 1'b1);
        push_item(REQ_RESTART, 8'h00,      1'b1);

        // Random records with some noise between them
        while (n_items < ITEM_GOAL) begin
            quiet <= (n_items >= 400 && n_items < 550);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    r = 2'($urandom_range(0, 3));
                    push_item(r, 8'($urandom_range(0, 255)), r != REQ_UNUSED);
                end
            end
            send_record();
        end
        s_valid <= 1'b0;

        // Drain
        do @(posedge aclk); while (pending_cnt != 0);
        repeat (4) @(posedge aclk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/csvrp_pkg.sv
src/csv_record_parser_fsm_core.sv
tb/sv/csv_parse_checker.sv
tb/sv/tb_csv_record_parser_fsm_core.sv
